/* design/delta_list_task_scheduler_macros.svh */
// assertion macros for the delta list task scheduler
`ifndef DELTA_LIST_TASK_SCHEDULER_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define DLTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DLTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dlts_pkg.sv */
// types and codes shared by the delta list scheduler modules
`timescale 1ns / 1ps

package dlts_pkg;

  localparam int DELTA_W = 29;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_DISP = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NONEDUE  = 2'd3;

  // cell operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;
  localparam logic [1:0] OP_REM  = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [7:0]         handle;
    logic [7:0]         ident;
    logic [DELTA_W-1:0] delta;
    logic [31:0]        period;
    logic [7:0]         runs;
  } entry_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [DELTA_W-1:0] rem;
    entry_t             fresh;
  } cell_ctl_t;

  typedef struct packed {
    logic               valid;
    logic               match;
    logic               le;
    logic [DELTA_W-1:0] delta;
  } probe_t;

endpackage

/* design/dlts_cell.sv */
// one table slot of the scheduler chain
`timescale 1ns / 1ps

module dlts_cell (
  input  logic               clk,
  input  logic               rst,
  input  dlts_pkg::cell_ctl_t ctl,
  input  logic               tok,
  input  logic               ge,
  input  dlts_pkg::entry_t   left,
  input  logic               left_tok,
  input  dlts_pkg::entry_t   right,
  output dlts_pkg::entry_t   ent,
  output dlts_pkg::probe_t   probe
);

  dlts_pkg::entry_t ent_next;

  // probe of this slot when the token sits here
  always_comb begin
    probe.valid = tok & ent.valid;
    probe.match = tok & ent.valid & (ent.ident == ctl.fresh.ident);
    probe.le    = tok & ent.valid & (ent.delta <= ctl.rem);
    probe.delta = tok ? ent.delta : '0;
  end

  // slot update: age, open a gap, or close one
  always_comb begin
    ent_next = ent;
    case (ctl.op)
      dlts_pkg::OP_TICK: begin
        if (tok && ent.valid) begin
          if (ent.delta == '0) begin
            if (ent.runs != 8'hFF) ent_next.runs = ent.runs + 8'd1;
          end else begin
            ent_next.delta = ent.delta - (dlts_pkg::DELTA_W)'(1);
          end
        end
      end
      dlts_pkg::OP_INS: begin
        if (tok) begin
          ent_next = ctl.fresh;
        end else if (ge) begin
          ent_next = left;
          if (left_tok) ent_next.delta = left.delta - ctl.rem;
        end
      end
      dlts_pkg::OP_REM: begin
        if (ge) begin
          ent_next = right;
          if (tok) ent_next.delta = right.delta + ent.delta;
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) ent.valid <= 1'b0;
    else ent <= ent_next;
  end

endmodule

/* design/dlts_div10.sv */
// divide by ten of a millisecond value into ticks by reciprocal multiply
`timescale 1ns / 1ps

module dlts_div10 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [31:0]                  dividend,
  output logic                         done,
  output logic [dlts_pkg::DELTA_W-1:0] quot
);

  logic [63:0] prod;

  // floor(x / 10) = (x * 0xCCCCCCCD) >> 35 for every 32-bit x
  assign quot = prod[35 +: dlts_pkg::DELTA_W];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= go;
  end

  always_ff @(posedge clk) begin
    if (go) prod <= {32'd0, dividend} * {32'd0, 32'hCCCCCCCD};
  end

endmodule

/* design/delta_list_task_scheduler.sv */
// top level: command sequencer over a chain of table slots
// Usage: raise start with cmd and its fields while busy is low; the beat is
// taken at that edge and busy rises on the next cycle. Each command yields
// exactly one result beat: done is high for one cycle with run_valid,
// run_handle, run_id, status and entry_count. The receiver cannot stall, so
// results must be sampled in that cycle; a new command may be started in the
// same cycle done is high.
// Command flow: a tick, an add with a full table and a one-shot or empty
// dispatch finish straight from the command state; a delete probes one slot
// per cycle as a token walks the chain; an add and a periodic dispatch first
// run the reciprocal-multiply divide by ten, then a token walk finds the
// insert position.
// Inserts/removals shift the token slot and later ones at once via neighbors.
// Reset (synchronous, active high) empties the table and returns to idle.
`timescale 1ns / 1ps
`include "delta_list_task_scheduler_macros.svh"

module delta_list_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [7:0]  task_handle,
  input  logic [7:0]  task_id,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  output logic        done,
  output logic        run_valid,
  output logic [7:0]  run_handle,
  output logic [7:0]  run_id,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int DW = dlts_pkg::DELTA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;

  logic [2:0]           state;
  logic [1:0]           cmd_r;
  logic [7:0]           hnd_r;
  logic [7:0]           id_r;
  logic [31:0]          dly_r;
  logic [31:0]          per_r;
  logic                 run_r;
  logic [MAX_TASKS-1:0] tok;
  logic [MAX_TASKS-1:0] ge;
  logic [DW-1:0]        rem;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_next;

  dlts_pkg::cell_ctl_t ctl;
  dlts_pkg::entry_t    ents   [MAX_TASKS];
  dlts_pkg::probe_t    probes [MAX_TASKS];
  dlts_pkg::probe_t    pr;
  dlts_pkg::entry_t    head;
  dlts_pkg::entry_t    no_entry;

  logic          div_go;
  logic [31:0]   div_in;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic          head_due;
  logic          run_now;
  logic [7:0]    hnd_now;
  logic [7:0]    id_now;

  assign busy     = (state != S_IDLE);
  assign head     = ents[0];
  assign head_due = head.valid && (head.runs != 8'd0);
  assign no_entry = '0;

  // dispatched task, also when the head leaves in this very cycle
  assign run_now = run_r || (state == S_CMD && cmd_r == dlts_pkg::CMD_DISP && head_due);
  assign hnd_now = run_r ? hnd_r : head.handle;
  assign id_now  = run_r ? id_r : head.ident;

  // slot chain
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    dlts_pkg::entry_t l_ent;
    dlts_pkg::entry_t r_ent;
    logic             l_tok;
    if (i == 0) begin : g_first
      assign l_ent = no_entry;
      assign l_tok = 1'b0;
    end else begin : g_mid
      assign l_ent = ents[i-1];
      assign l_tok = tok[i-1];
    end
    if (i == MAX_TASKS - 1) begin : g_last
      assign r_ent = no_entry;
    end else begin : g_more
      assign r_ent = ents[i+1];
    end
    dlts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .tok      (tok[i]),
      .ge       (ge[i]),
      .left     (l_ent),
      .left_tok (l_tok),
      .right    (r_ent),
      .ent      (ents[i]),
      .probe    (probes[i])
    );
  end

  // only the token slot drives its probe
  always_comb begin
    pr = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      pr = dlts_pkg::probe_t'(pr | probes[i]);
    end
  end

  dlts_div10 u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_in),
    .done     (div_done),
    .quot     (div_q)
  );

  // divider launch: new add, or re-queue of a periodic head
  always_comb begin
    div_go = 1'b0;
    div_in = dly_r;
    if (state == S_CMD) begin
      if (cmd_r == dlts_pkg::CMD_ADD && cnt != CW'(MAX_TASKS)) begin
        div_go = 1'b1;
      end else if (cmd_r == dlts_pkg::CMD_DISP && head_due && head.period != '0) begin
        div_go = 1'b1;
        div_in = head.period;
      end
    end
  end

  // chain operation for this cycle
  always_comb begin
    ctl.op           = dlts_pkg::OP_NONE;
    ctl.rem          = rem;
    ctl.fresh.valid  = 1'b1;
    ctl.fresh.handle = hnd_r;
    ctl.fresh.ident  = id_r;
    ctl.fresh.delta  = rem;
    ctl.fresh.period = per_r;
    ctl.fresh.runs   = 8'd0;
    case (state)
      S_CMD: begin
        if (cmd_r == dlts_pkg::CMD_TICK) ctl.op = dlts_pkg::OP_TICK;
        else if (cmd_r == dlts_pkg::CMD_DISP && head_due) ctl.op = dlts_pkg::OP_REM;
      end
      S_WALK: if (!pr.le) ctl.op = dlts_pkg::OP_INS;
      S_FIND: if (pr.match) ctl.op = dlts_pkg::OP_REM;
      default: ctl.op = dlts_pkg::OP_NONE;
    endcase
  end

  // occupancy follows the chain operation
  always_comb begin
    cnt_next = cnt;
    if (ctl.op == dlts_pkg::OP_INS) cnt_next = cnt + CW'(1);
    else if (ctl.op == dlts_pkg::OP_REM) cnt_next = cnt - CW'(1);
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      tok   <= MAX_TASKS'(1);
      ge    <= '1;
      run_r <= 1'b0;
    end else begin
      done <= 1'b0;
      cnt  <= cnt_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            hnd_r <= task_handle;
            id_r  <= task_id;
            dly_r <= delay_ms;
            per_r <= period_ms;
            run_r <= 1'b0;
            tok   <= MAX_TASKS'(1);
            ge    <= '1;
            state <= S_CMD;
          end
        end
        S_CMD: begin
          case (cmd_r)
            dlts_pkg::CMD_TICK: begin
              state <= S_IDLE;
              done  <= 1'b1;
              status <= dlts_pkg::ST_OK;
            end
            dlts_pkg::CMD_ADD: begin
              if (cnt == CW'(MAX_TASKS)) begin
                state  <= S_IDLE;
                done   <= 1'b1;
                status <= dlts_pkg::ST_FULL;
              end else begin
                state <= S_DIV;
              end
            end
            dlts_pkg::CMD_DEL: state <= S_FIND;
            default: begin
              if (head_due) begin
                run_r <= 1'b1;
                hnd_r <= head.handle;
                id_r  <= head.ident;
                per_r <= head.period;
                if (head.period != '0) begin
                  state <= S_DIV;
                end else begin
                  state  <= S_IDLE;
                  done   <= 1'b1;
                  status <= dlts_pkg::ST_OK;
                end
              end else begin
                state  <= S_IDLE;
                done   <= 1'b1;
                status <= dlts_pkg::ST_NONEDUE;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            rem   <= div_q;
            tok   <= MAX_TASKS'(1);
            ge    <= '1;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (pr.le) begin
            rem <= rem - pr.delta;
            tok <= tok << 1;
            ge  <= ge << 1;
          end else begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= dlts_pkg::ST_OK;
          end
        end
        S_FIND: begin
          if (pr.match) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= dlts_pkg::ST_OK;
          end else if (!pr.valid || tok[MAX_TASKS-1]) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= dlts_pkg::ST_NOTFOUND;
          end else begin
            tok <= tok << 1;
            ge  <= ge << 1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result beat payload, registered every cycle so it is current when done rises
  always_ff @(posedge clk) begin
    entry_count <= 5'(cnt_next);
    run_valid   <= run_now;
    run_handle  <= run_now ? hnd_now : 8'd0;
    run_id      <= run_now ? id_now : 8'd0;
  end

  // checks
  `DLTS_ASSERT_NOW(a_done_idle, done, !busy, "result beat while sequencer busy")
  `DLTS_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "command not taken")
  `DLTS_ASSERT_NOW(a_run_ok, done && run_valid, status == dlts_pkg::ST_OK, "run with bad status")
  `DLTS_ASSERT_NOW(a_tok_onehot, busy, $onehot(tok), "walk token lost")

endmodule

/* tb/sv/dlts_checker.sv */
// scoreboard for the delta list task scheduler: table prediction and result compare
`timescale 1ns / 1ps

module dlts_checker #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd,
  input  logic [7:0]  task_handle,
  input  logic [7:0]  task_id,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  input  logic        done,
  input  logic        run_valid,
  input  logic [7:0]  run_handle,
  input  logic [7:0]  run_id,
  input  logic [1:0]  status,
  input  logic [4:0]  entry_count,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic       run_valid;
    logic [7:0] run_handle;
    logic [7:0] run_id;
    logic [1:0] status;
    logic [4:0] entry_count;
  } outcome_t;

  // predicted task table, packed at the front
  logic [7:0]                   tq_handle [MAX_TASKS];
  logic [7:0]                   tq_ident  [MAX_TASKS];
  logic [dlts_pkg::DELTA_W-1:0] tq_delta  [MAX_TASKS];
  logic [31:0]                  tq_period [MAX_TASKS];
  logic [7:0]                   tq_runs   [MAX_TASKS];
  int                           tq_len;
  outcome_t                     outcome_q[$];

  assign pending = outcome_q.size();

  // sorted insert; false when the table is full
  function automatic bit enqueue_task(logic [7:0] h, logic [7:0] d,
                                      logic [31:0] dly, logic [31:0] per);
    int pos;
    logic [dlts_pkg::DELTA_W-1:0] rem;
    logic [31:0] ticks;
    pos = 0;
    ticks = dly / 32'd10;
    rem = ticks[dlts_pkg::DELTA_W-1:0];
    if (tq_len >= MAX_TASKS) return 0;
    while (pos < tq_len && tq_delta[pos] <= rem) begin
      rem = rem - tq_delta[pos];
      pos++;
    end
    for (int i = tq_len; i > pos; i--) begin
      tq_handle[i] = tq_handle[i-1];
      tq_ident[i]  = tq_ident[i-1];
      tq_delta[i]  = tq_delta[i-1];
      tq_period[i] = tq_period[i-1];
      tq_runs[i]   = tq_runs[i-1];
    end
    tq_handle[pos] = h;
    tq_ident[pos]  = d;
    tq_delta[pos]  = rem;
    tq_period[pos] = per;
    tq_runs[pos]   = 8'd0;
    if (pos < tq_len) tq_delta[pos+1] = tq_delta[pos+1] - rem;
    tq_len++;
    return 1;
  endfunction

  // removal folds the remaining delta into the successor
  function automatic void drop_task(int pos);
    if (pos + 1 < tq_len) tq_delta[pos+1] = tq_delta[pos+1] + tq_delta[pos];
    for (int i = pos; i + 1 < tq_len; i++) begin
      tq_handle[i] = tq_handle[i+1];
      tq_ident[i]  = tq_ident[i+1];
      tq_delta[i]  = tq_delta[i+1];
      tq_period[i] = tq_period[i+1];
      tq_runs[i]   = tq_runs[i+1];
    end
    tq_len--;
  endfunction

  function automatic outcome_t schedule_step(logic [1:0] c, logic [7:0] h, logic [7:0] d,
                                             logic [31:0] dly, logic [31:0] per);
    outcome_t o;
    int idx;
    logic [7:0] hh, dd;
    logic [31:0] pp;
    o = '{1'b0, 8'd0, 8'd0, dlts_pkg::ST_OK, 5'd0};
    case (c)
      dlts_pkg::CMD_TICK: begin
        if (tq_len > 0) begin
          if (tq_delta[0] == '0) begin
            if (tq_runs[0] != 8'd255) tq_runs[0]++;
          end else tq_delta[0]--;
        end
      end
      dlts_pkg::CMD_ADD: begin
        if (!enqueue_task(h, d, dly, per)) o.status = dlts_pkg::ST_FULL;
      end
      dlts_pkg::CMD_DEL: begin
        idx = -1;
        for (int i = 0; i < tq_len; i++)
          if (idx < 0 && tq_ident[i] == d) idx = i;
        if (idx >= 0) drop_task(idx);
        else o.status = dlts_pkg::ST_NOTFOUND;
      end
      default: begin
        if (tq_len > 0 && tq_runs[0] != 8'd0) begin
          hh = tq_handle[0];
          dd = tq_ident[0];
          pp = tq_period[0];
          o.run_valid = 1'b1;
          o.run_handle = hh;
          o.run_id = dd;
          drop_task(0);
          if (pp != 0) void'(enqueue_task(hh, dd, pp, pp));
        end else o.status = dlts_pkg::ST_NONEDUE;
      end
    endcase
    o.entry_count = tq_len[4:0];
    return o;
  endfunction

  // accept command beats and compare result beats
  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      tq_len = 0;
      errors = 0;
      outcome_q.delete();
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = outcome_q.pop_front();
          if (run_valid !== e.run_valid) begin
            $error("run_valid exp %0h got %0h", e.run_valid, run_valid); errors++;
          end
          if (run_handle !== e.run_handle) begin
            $error("run_handle exp %0h got %0h", e.run_handle, run_handle); errors++;
          end
          if (run_id !== e.run_id) begin
            $error("run_id exp %0h got %0h", e.run_id, run_id); errors++;
          end
          if (status !== e.status) begin
            $error("status exp %0h got %0h", e.status, status); errors++;
          end
          if (entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, entry_count); errors++;
          end
        end
      end
      if (start && !busy)
        outcome_q.push_back(schedule_step(cmd, task_handle, task_id, delay_ms, period_ms));
    end
  end
endmodule

/* tb/sv/tb_delta_list_task_scheduler.sv */
// testbench top: command stimulus, idle gaps and verdict
`timescale 1ns / 1ps

module tb_delta_list_task_scheduler;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = dlts_pkg::CMD_TICK;
  logic [7:0]  task_handle = '0;
  logic [7:0]  task_id = '0;
  logic [31:0] delay_ms = '0;
  logic [31:0] period_ms = '0;
  logic        done, run_valid;
  logic [7:0]  run_handle, run_id;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  int          errors, pending, idle_cycles;

  always #1 clk = ~clk;

  delta_list_task_scheduler dut (.*);
  dlts_checker chk (.*);

  // watchdog on cycles with no beat taken
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles > WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one command beat, then an occasional gap
  task automatic issue(logic [1:0] c, logic [7:0] h, logic [7:0] d,
                       logic [31:0] dly, logic [31:0] per, bit gaps);
    int g;
    cmd <= c; task_handle <= h; task_id <= d; delay_ms <= dly; period_ms <= per;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    g = 0;
    if (gaps) begin
      g = $urandom_range(0, 9);
      g = (g < 6) ? 0 : (g < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_ms();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 9);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  initial begin
    int r;
    logic [1:0] c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty table cases, extremes, ties, full table, delete fold
    issue(dlts_pkg::CMD_TICK, 8'h00, 8'h00, 32'h0, 32'h0, 0);
    issue(dlts_pkg::CMD_DISP, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff, 0);
    issue(dlts_pkg::CMD_DEL, 8'h00, 8'h55, 32'h0, 32'h0, 0);
    issue(dlts_pkg::CMD_ADD, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff, 0);
    issue(dlts_pkg::CMD_ADD, 8'h00, 8'h00, 32'd9, 32'd25, 0);
    issue(dlts_pkg::CMD_ADD, 8'haa, 8'h01, 32'd0, 32'd0, 0);
    issue(dlts_pkg::CMD_ADD, 8'h55, 8'h02, 32'd30, 32'd0, 0);
    issue(dlts_pkg::CMD_ADD, 8'h5a, 8'h03, 32'd39, 32'd10, 0);
    issue(dlts_pkg::CMD_TICK, 8'h00, 8'h00, 32'h0, 32'h0, 0);
    issue(dlts_pkg::CMD_DISP, 8'h00, 8'h00, 32'h0, 32'h0, 0);
    issue(dlts_pkg::CMD_DISP, 8'h00, 8'h00, 32'h0, 32'h0, 0);
    issue(dlts_pkg::CMD_DEL, 8'h00, 8'h02, 32'h0, 32'h0, 0);
    for (int i = 0; i < 14; i++)
      issue(dlts_pkg::CMD_ADD, 8'(i), 8'(16 + i), 32'(i * 20), 32'd0, 0);
    for (int i = 0; i < 300; i++) issue(dlts_pkg::CMD_TICK, 8'h0, 8'h0, 32'h0, 32'h0, 0);
    // pause until all expectations are met
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    for (int i = 0; i < 20; i++)
      issue(dlts_pkg::CMD_DEL, 8'h0, 8'(16 + i), 32'h0, 32'h0, 1);
    // random: weighted toward ticks and dispatch of a small table with periodic tasks
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 40) ? dlts_pkg::CMD_TICK : (r < 60) ? dlts_pkg::CMD_ADD :
          (r < 72) ? dlts_pkg::CMD_DEL : dlts_pkg::CMD_DISP;
      issue(c, 8'($urandom), (r % 3 == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
            rand_ms(), ($urandom_range(0, 2) == 0) ? 32'd0 : rand_ms(), 1);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

/* delta_list_task_scheduler.f */
+incdir+design
design/dlts_pkg.sv
design/dlts_cell.sv
design/dlts_div10.sv
design/delta_list_task_scheduler.sv
tb/sv/dlts_checker.sv
tb/sv/tb_delta_list_task_scheduler.sv
